// File: hw/rtl/icdte_pkg.sv
// Shared widths, character codes and arithmetic constants for the iCal datetime
// to epoch converter, plus small helper functions. No dependencies.
package icdte_pkg;

	localparam int unsigned LEN_W    = 5;
	localparam int unsigned DATE_W   = 64;
	localparam int unsigned TIME_W   = 48;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned OFFSET_W = 17;
	localparam int unsigned EPOCH_W  = 39;

	// internal widths, sized to the ranges that byte-minus-48 digits can reach
	localparam int unsigned DIGIT_W = 10;
	localparam int unsigned YEAR_W  = 19;
	localparam int unsigned FLD_W   = 13;
	localparam int unsigned MAG_W   = 18;
	localparam int unsigned PROD_W  = 2 * MAG_W;
	localparam int unsigned Q4_W    = 16;
	localparam int unsigned Q100_W  = 12;
	localparam int unsigned Q400_W  = 10;
	localparam int unsigned REM_W   = 8;
	localparam int unsigned MD_W    = 14;
	localparam int unsigned HMS_W   = 25;
	localparam int unsigned LEAP_W  = 18;
	localparam int unsigned DAYS_W  = 28;
	localparam int unsigned TOT_W   = 46;

	localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
	localparam logic [LEN_W-1:0]  LEN_DATE   = 5'd8;
	localparam logic [LEN_W-1:0]  LEN_TIME   = 5'd15;
	localparam logic [LEN_W-1:0]  LEN_ZONE   = 5'd16;

	localparam logic signed [YEAR_W-1:0] YEAR_1601 = 19'sd1601;
	localparam logic signed [YEAR_W-1:0] YEAR_1901 = 19'sd1901;
	localparam logic signed [YEAR_W-1:0] YEAR_1969 = 19'sd1969;
	localparam logic signed [YEAR_W-1:0] YEAR_1970 = 19'sd1970;

	localparam logic signed [FLD_W-1:0] MONTH_MIN = 13'sd1;
	localparam logic signed [FLD_W-1:0] MONTH_MAX = 13'sd12;
	localparam logic signed [FLD_W-1:0] MONTH_FEB = 13'sd2;

	localparam logic signed [9:0]  DAYS_PER_YEAR = 10'sd365;
	localparam logic signed [17:0] SEC_PER_DAY   = 18'sd86400;
	localparam logic signed [12:0] SEC_PER_HOUR  = 13'sd3600;
	localparam logic signed [7:0]  SEC_PER_MIN   = 8'sd60;

	// floor(2^24/100) and floor(2^26/400) are the same number; the estimate is
	// at most one short for any 18-bit magnitude
	localparam logic [MAG_W-1:0]   RECIP_DIV = 18'd167772;
	localparam int unsigned        SH_100    = 24;
	localparam int unsigned        SH_400    = 26;
	localparam logic [MAG_W-1:0]   DIV_100   = 18'd100;
	localparam logic [MAG_W-1:0]   DIV_400   = 18'd400;

	localparam logic signed [TOT_W-1:0] EPOCH_MAX = 46'sd274877906943;
	localparam logic signed [TOT_W-1:0] EPOCH_MIN = -46'sd274877906944;

	function automatic logic signed [DIGIT_W-1:0] digit_val(input logic [CHAR_W-1:0] ch);
		return $signed({2'b00, ch}) - 10'sd48;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [MAG_W-1:0] magnitude(input logic signed [YEAR_W-1:0] x);
		logic signed [YEAR_W-1:0] n;
		n = -x;
		return x[YEAR_W-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
	endfunction

	function automatic logic signed [LEAP_W-1:0] with_sign(input logic neg,
	                                                       input logic [Q4_W-1:0] q);
		logic signed [LEAP_W-1:0] v;
		v = $signed({2'b00, q});
		return neg ? -v : v;
	endfunction

endpackage

// File: hw/rtl/icdte_req_if.sv
// Request channel of the datetime converter: the packed iCal text.
// Depends on icdte_pkg.
interface icdte_req_if import icdte_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [LEN_W-1:0]    text_length;
	logic [DATE_W-1:0]   date_chars;
	logic [CHAR_W-1:0]   separator_char;
	logic [TIME_W-1:0]   time_chars;
	logic [CHAR_W-1:0]   zone_char;

	modport source (output valid, text_length, date_chars, separator_char, time_chars,
	                zone_char, input ready);
	modport sink (input valid, text_length, date_chars, separator_char, time_chars,
	              zone_char, output ready);
endinterface

// File: hw/rtl/icdte_rsp_if.sv
// Result channel of the datetime converter: epoch seconds and month flag.
// Depends on icdte_pkg.
interface icdte_rsp_if import icdte_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [EPOCH_W-1:0]  epoch_seconds;
	logic                       bad_month;

	modport source (output valid, epoch_seconds, bad_month, input ready);
	modport sink (input valid, epoch_seconds, bad_month, output ready);
endinterface

// File: hw/rtl/icdte_cfg_if.sv
// Configuration write channel of the datetime converter: local zone offset.
// Depends on icdte_pkg.
interface icdte_cfg_if import icdte_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [OFFSET_W-1:0]  local_offset_seconds;

	modport source (output valid, local_offset_seconds, input ready);
	modport sink (input valid, local_offset_seconds, output ready);
endinterface

// File: hw/rtl/ical_datetime_to_epoch_unit.sv
// Converts one packed iCal date or datetime text per request into signed Unix
// seconds. One request is taken every cycle; the nine-stage pipeline moves as a whole,
// so ready falls only while a finished result sits unclaimed in the output stage.
// Texts shorter than eight characters give 0; a month outside 1..12 gives 0 with
// bad_month set. Texts without a 'Z' mark, date-only texts included, have the local
// offset subtracted; the offset register is always writeable and resets to 0. The
// day count multiply (28 x 18 bits) sets the depth of the longest stage.
// Depends on icdte_pkg, icdte_req_if, icdte_rsp_if and icdte_cfg_if.
module ical_datetime_to_epoch_unit import icdte_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	icdte_cfg_if.sink   cfg,
	icdte_req_if.sink   req,
	icdte_rsp_if.source rsp
);

	logic signed [OFFSET_W-1:0] offset_q;
	logic                       adv;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// stage 1
	logic signed [DIGIT_W-1:0] dd [8];
	logic signed [DIGIT_W-1:0] td [6];
	logic signed [YEAR_W-1:0]  year_c;
	logic signed [FLD_W-1:0]   month_c, day_c, hour_c, minute_c, second_c;
	logic                      short_c, badm_c, use_time_c, utc_c;
	logic signed [YEAR_W-1:0]  year_s1;
	logic signed [FLD_W-1:0]   month_s1, day_s1, hour_s1, minute_s1, second_s1;
	logic                      zero_s1, bad_s1, local_s1;

	// stage 2
	logic [MAG_W-1:0]          mag_a_s2, mag_b_s2, mag_c_s2, mag_y_s2;
	logic                      neg_a_s2, neg_b_s2, neg_c_s2, ylow0_s2;
	logic signed [YEAR_W-1:0]  yoff_s2;
	logic signed [MD_W-1:0]    md_s2;
	logic                      late_s2;
	logic signed [HMS_W-1:0]   hms_s2;
	logic                      zero_s2, bad_s2, local_s2;

	// stage 3
	logic [PROD_W-1:0]         pb_c, pc_c, py_c;
	logic [Q4_W-1:0]           qa_s3;
	logic [Q100_W-1:0]         qb0_s3, qy0_s3;
	logic [Q400_W-1:0]         qc0_s3;
	logic [MAG_W-1:0]          mag_b_s3, mag_c_s3, mag_y_s3;
	logic                      neg_a_s3, neg_b_s3, neg_c_s3, ylow0_s3;
	logic signed [DAYS_W-1:0]  y365_s3;
	logic signed [MD_W-1:0]    md_s3;
	logic                      late_s3;
	logic signed [HMS_W-1:0]   hms_s3;
	logic                      zero_s3, bad_s3, local_s3;

	// stage 4
	logic [MAG_W-1:0]          rb_c, rc_c, ry_c;
	logic [REM_W-1:0]          ry_fix_c;
	logic                      cb_c, cc_c, cy_c, leap_c;
	logic [Q100_W-1:0]         qy_c;
	logic [Q4_W-1:0]           qa_s4;
	logic [Q100_W-1:0]         qb_s4;
	logic [Q400_W-1:0]         qc_s4;
	logic                      neg_a_s4, neg_b_s4, neg_c_s4, extra_s4;
	logic signed [DAYS_W-1:0]  y365_s4;
	logic signed [MD_W-1:0]    md_s4;
	logic signed [HMS_W-1:0]   hms_s4;
	logic                      zero_s4, bad_s4, local_s4;

	// stages 5 to 9
	logic signed [LEAP_W-1:0]  leaps_s5;
	logic                      extra_s5;
	logic signed [DAYS_W-1:0]  y365_s5;
	logic signed [MD_W-1:0]    md_s5;
	logic signed [HMS_W-1:0]   hms_s5;
	logic                      zero_s5, bad_s5, local_s5;

	logic signed [DAYS_W-1:0]  days_s6;
	logic signed [HMS_W-1:0]   hms_s6;
	logic                      zero_s6, bad_s6, local_s6;

	logic signed [TOT_W-1:0]   prod_s7;
	logic signed [HMS_W-1:0]   hms_s7;
	logic                      zero_s7, bad_s7, local_s7;

	logic signed [TOT_W-1:0]   off_c;
	logic signed [TOT_W-1:0]   total_s8;
	logic                      zero_s8, bad_s8;

	logic signed [TOT_W-1:0]   sat_c;
	logic signed [EPOCH_W-1:0] epoch_s9;
	logic                      bad_s9;

	// whole pipeline advances unless the result stage is held
	assign adv       = !v_s9 || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg.valid) begin
			offset_q <= cfg.local_offset_seconds;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1: character decode and range checks
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			dd[i] = digit_val(req.date_chars[DATE_W-1-CHAR_W*i -: CHAR_W]);
		end
		for (int i = 0; i < 6; i++) begin
			td[i] = digit_val(req.time_chars[TIME_W-1-CHAR_W*i -: CHAR_W]);
		end
		year_c = YEAR_W'(dd[0]) * 19'sd1000 + YEAR_W'(dd[1]) * 19'sd100
		       + YEAR_W'(dd[2]) * 19'sd10 + YEAR_W'(dd[3]);
		month_c = FLD_W'(dd[4]) * 13'sd10 + FLD_W'(dd[5]);
		day_c   = FLD_W'(dd[6]) * 13'sd10 + FLD_W'(dd[7]);
		use_time_c = (req.text_length >= LEN_TIME) && (req.separator_char == CHAR_T);
		utc_c      = use_time_c && (req.text_length >= LEN_ZONE) && (req.zone_char == CHAR_Z);
		hour_c   = use_time_c ? FLD_W'(td[0]) * 13'sd10 + FLD_W'(td[1]) : '0;
		minute_c = use_time_c ? FLD_W'(td[2]) * 13'sd10 + FLD_W'(td[3]) : '0;
		second_c = use_time_c ? FLD_W'(td[4]) * 13'sd10 + FLD_W'(td[5]) : '0;
		short_c  = req.text_length < LEN_DATE;
		badm_c   = (month_c < MONTH_MIN) || (month_c > MONTH_MAX);
	end

	// stage 4: one-step quotient correction, leap year test
	always_comb begin
		rb_c = mag_b_s3 - MAG_W'(qb0_s3) * DIV_100;
		rc_c = mag_c_s3 - MAG_W'(qc0_s3) * DIV_400;
		ry_c = mag_y_s3 - MAG_W'(qy0_s3) * DIV_100;
		cb_c = rb_c >= DIV_100;
		cc_c = rc_c >= DIV_400;
		cy_c = ry_c >= DIV_100;
		ry_fix_c = cy_c ? REM_W'(ry_c - DIV_100) : REM_W'(ry_c);
		qy_c = qy0_s3 + Q100_W'(cy_c);
		// divisible by 4, and either not by 100 or also by 400
		leap_c = ylow0_s3 && ((ry_fix_c != '0) || (qy_c[1:0] == 2'b00));
	end

	assign pb_c = PROD_W'(mag_b_s2) * PROD_W'(RECIP_DIV);
	assign pc_c = PROD_W'(mag_c_s2) * PROD_W'(RECIP_DIV);
	assign py_c = PROD_W'(mag_y_s2) * PROD_W'(RECIP_DIV);

	assign off_c = local_s7 ? TOT_W'(offset_q) : '0;

	always_comb begin
		if (zero_s8) begin
			sat_c = '0;
		end else if (total_s8 > EPOCH_MAX) begin
			sat_c = EPOCH_MAX;
		end else if (total_s8 < EPOCH_MIN) begin
			sat_c = EPOCH_MIN;
		end else begin
			sat_c = total_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			year_s1   <= year_c;
			month_s1  <= month_c;
			day_s1    <= day_c;
			hour_s1   <= hour_c;
			minute_s1 <= minute_c;
			second_s1 <= second_c;
			zero_s1   <= short_c || badm_c;
			bad_s1    <= !short_c && badm_c;
			local_s1  <= !utc_c;

			// stage 2: magnitudes for truncating division, month and time sums
			mag_a_s2 <= magnitude(year_s1 - YEAR_1969);
			neg_a_s2 <= year_s1 < YEAR_1969;
			mag_b_s2 <= magnitude(year_s1 - YEAR_1901);
			neg_b_s2 <= year_s1 < YEAR_1901;
			mag_c_s2 <= magnitude(year_s1 - YEAR_1601);
			neg_c_s2 <= year_s1 < YEAR_1601;
			mag_y_s2 <= magnitude(year_s1);
			ylow0_s2 <= year_s1[1:0] == 2'b00;
			yoff_s2  <= year_s1 - YEAR_1970;
			md_s2    <= $signed({5'b00000, month_start(month_s1[3:0])})
			          + MD_W'(day_s1) - 14'sd1;
			late_s2  <= month_s1 > MONTH_FEB;
			hms_s2   <= HMS_W'(hour_s1) * HMS_W'(SEC_PER_HOUR)
			          + HMS_W'(minute_s1) * HMS_W'(SEC_PER_MIN) + HMS_W'(second_s1);
			zero_s2  <= zero_s1;
			bad_s2   <= bad_s1;
			local_s2 <= local_s1;

			// stage 3: reciprocal estimates, year days
			qa_s3    <= mag_a_s2[MAG_W-1:2];
			qb0_s3   <= pb_c[SH_100 +: Q100_W];
			qc0_s3   <= pc_c[SH_400 +: Q400_W];
			qy0_s3   <= py_c[SH_100 +: Q100_W];
			mag_b_s3 <= mag_b_s2;
			mag_c_s3 <= mag_c_s2;
			mag_y_s3 <= mag_y_s2;
			neg_a_s3 <= neg_a_s2;
			neg_b_s3 <= neg_b_s2;
			neg_c_s3 <= neg_c_s2;
			ylow0_s3 <= ylow0_s2;
			y365_s3  <= DAYS_W'(yoff_s2) * DAYS_W'(DAYS_PER_YEAR);
			md_s3    <= md_s2;
			late_s3  <= late_s2;
			hms_s3   <= hms_s2;
			zero_s3  <= zero_s2;
			bad_s3   <= bad_s2;
			local_s3 <= local_s2;

			// stage 4
			qa_s4    <= qa_s3;
			qb_s4    <= qb0_s3 + Q100_W'(cb_c);
			qc_s4    <= qc0_s3 + Q400_W'(cc_c);
			neg_a_s4 <= neg_a_s3;
			neg_b_s4 <= neg_b_s3;
			neg_c_s4 <= neg_c_s3;
			extra_s4 <= leap_c && late_s3;
			y365_s4  <= y365_s3;
			md_s4    <= md_s3;
			hms_s4   <= hms_s3;
			zero_s4  <= zero_s3;
			bad_s4   <= bad_s3;
			local_s4 <= local_s3;

			// stage 5: leap day count
			leaps_s5 <= with_sign(neg_a_s4, qa_s4) - with_sign(neg_b_s4, Q4_W'(qb_s4))
			          + with_sign(neg_c_s4, Q4_W'(qc_s4));
			extra_s5 <= extra_s4;
			y365_s5  <= y365_s4;
			md_s5    <= md_s4;
			hms_s5   <= hms_s4;
			zero_s5  <= zero_s4;
			bad_s5   <= bad_s4;
			local_s5 <= local_s4;

			// stage 6: day number
			days_s6  <= y365_s5 + DAYS_W'(leaps_s5) + DAYS_W'(md_s5)
			          + $signed({{(DAYS_W-1){1'b0}}, extra_s5});
			hms_s6   <= hms_s5;
			zero_s6  <= zero_s5;
			bad_s6   <= bad_s5;
			local_s6 <= local_s5;

			// stage 7
			prod_s7  <= TOT_W'(days_s6) * TOT_W'(SEC_PER_DAY);
			hms_s7   <= hms_s6;
			zero_s7  <= zero_s6;
			bad_s7   <= bad_s6;
			local_s7 <= local_s6;

			// stage 8
			total_s8 <= prod_s7 + TOT_W'(hms_s7) - off_c;
			zero_s8  <= zero_s7;
			bad_s8   <= bad_s7;

			// stage 9: clamp to the 39-bit range
			epoch_s9 <= sat_c[EPOCH_W-1:0];
			bad_s9   <= bad_s8;
		end
	end

	assign rsp.valid         = v_s9;
	assign rsp.epoch_seconds = epoch_s9;
	assign rsp.bad_month     = bad_s9;

endmodule

// File: tb/icdte_epoch_checker.sv
`timescale 1ns / 100ps
// Checker for the iCal datetime converter: watches the offset, request and result
// channels, predicts each result and compares. Depends on icdte_pkg and the channel interfaces.
module icdte_epoch_checker import icdte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	icdte_cfg_if  cfg,
	icdte_req_if  req,
	icdte_rsp_if  rsp,
	output int    errors,
	output int    outstanding,
	output int    checked,
	output int    flagged
);

	typedef struct packed {
		logic signed [EPOCH_W-1:0] epoch;
		logic                      bad;
	} epoch_result_t;

	localparam longint CUM_MONTH_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
		304, 334};
	localparam longint EPOCH_TOP    = 64'sd274877906943;
	localparam longint EPOCH_BOTTOM = -64'sd274877906944;

	epoch_result_t epoch_expected_q [$];
	longint        offset_now = 0;
	int            mismatches = 0;
	int            results_seen = 0;
	int            bad_seen = 0;

	function automatic longint char_digit(input logic [CHAR_W-1:0] c);
		return longint'({56'd0, c}) - 48;
	endfunction

	function automatic epoch_result_t predict_epoch(input logic [LEN_W-1:0] len,
	                                                input logic [DATE_W-1:0] date,
	                                                input logic [CHAR_W-1:0] sep,
	                                                input logic [TIME_W-1:0] tm,
	                                                input logic [CHAR_W-1:0] zone,
	                                                input longint offset);
		epoch_result_t r;
		longint yr, mon, dy, hr, mn, sc, leaps, days, total;
		bit leap, utc;
		r.epoch = '0;
		r.bad = 1'b0;
		if (len < LEN_DATE)
			return r;
		yr = char_digit(date[63:56]) * 1000 + char_digit(date[55:48]) * 100
		   + char_digit(date[47:40]) * 10 + char_digit(date[39:32]);
		mon = char_digit(date[31:24]) * 10 + char_digit(date[23:16]);
		dy = char_digit(date[15:8]) * 10 + char_digit(date[7:0]);
		if (mon < 1 || mon > 12) begin
			r.bad = 1'b1;
			return r;
		end
		hr = 0;
		mn = 0;
		sc = 0;
		utc = 1'b0;
		if (len >= LEN_TIME && sep == CHAR_T) begin
			hr = char_digit(tm[47:40]) * 10 + char_digit(tm[39:32]);
			mn = char_digit(tm[31:24]) * 10 + char_digit(tm[23:16]);
			sc = char_digit(tm[15:8]) * 10 + char_digit(tm[7:0]);
			// zone mark only counts once the text actually reaches it
			utc = (len >= LEN_ZONE) && (zone == CHAR_Z);
		end
		// truncating division, so negative years round towards zero
		leaps = (yr - 1969) / 4 - (yr - 1901) / 100 + (yr - 1601) / 400;
		leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
		days = (yr - 1970) * 365 + leaps + CUM_MONTH_DAYS[mon - 1]
		     + ((leap && mon > 2) ? 1 : 0) + dy - 1;
		total = days * 86400 + hr * 3600 + mn * 60 + sc;
		if (!utc)
			total -= offset;
		if (total > EPOCH_TOP)
			total = EPOCH_TOP;
		else if (total < EPOCH_BOTTOM)
			total = EPOCH_BOTTOM;
		r.epoch = total[EPOCH_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		epoch_result_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				offset_now = longint'(cfg.local_offset_seconds);
			if (req.valid && req.ready)
				epoch_expected_q.push_back(predict_epoch(req.text_length, req.date_chars,
					req.separator_char, req.time_chars, req.zone_char, offset_now));
			if (rsp.valid && rsp.ready) begin
				if (epoch_expected_q.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request pending: expected none, got epoch %0d bad_month %0b",
						$time, rsp.epoch_seconds, rsp.bad_month);
				end else begin
					want = epoch_expected_q.pop_front();
					if (rsp.epoch_seconds !== want.epoch) begin
						mismatches++;
						$display("%0t: epoch_seconds expected %0d got %0d", $time,
							$signed(want.epoch), rsp.epoch_seconds);
					end
					if (rsp.bad_month !== want.bad) begin
						mismatches++;
						$display("%0t: bad_month expected %0b got %0b", $time, want.bad,
							rsp.bad_month);
					end
					results_seen++;
					if (want.bad)
						bad_seen++;
				end
			end
		end
		errors <= mismatches;
		outstanding <= epoch_expected_q.size();
		checked <= results_seen;
		flagged <= bad_seen;
	end

endmodule

// File: tb/ical_datetime_to_epoch_unit_tb.sv
`timescale 1ns / 100ps
// Top of the datetime converter bench: clock, reset, request and offset stimulus,
// result back-pressure and verdict. Depends on icdte_pkg, the interfaces and icdte_epoch_checker.
module ical_datetime_to_epoch_unit_tb;
	import icdte_pkg::*;

	logic clk;
	logic arst_n;

	icdte_cfg_if cfg_ch ();
	icdte_req_if req_ch ();
	icdte_rsp_if rsp_ch ();

	int errors, outstanding, checked, flagged;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int offset_writes = 0;

	ical_datetime_to_epoch_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	icdte_epoch_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.flagged     (flagged)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [15:0] two_digits(input int n);
		return {8'(48 + n / 10), 8'(48 + n % 10)};
	endfunction

	function automatic logic [DATE_W-1:0] date_text(input int y, input int m, input int d);
		return {two_digits(y / 100), two_digits(y % 100), two_digits(m), two_digits(d)};
	endfunction

	function automatic logic [TIME_W-1:0] clock_text(input int h, input int m, input int s);
		return {two_digits(h), two_digits(m), two_digits(s)};
	endfunction

	task automatic send_text(input logic [LEN_W-1:0] len, input logic [DATE_W-1:0] date,
	                         input logic [CHAR_W-1:0] sep, input logic [TIME_W-1:0] tm,
	                         input logic [CHAR_W-1:0] zone);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.text_length    <= len;
		req_ch.date_chars     <= date;
		req_ch.separator_char <= sep;
		req_ch.time_chars     <= tm;
		req_ch.zone_char      <= zone;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	// checker counts are registered, so look only from the next edge on
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
		wait_all_results();
		repeat (12) @(posedge clk);
		cfg_ch.valid                <= 1'b1;
		cfg_ch.local_offset_seconds <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		offset_writes++;
	endtask

	initial begin : stimulus
		int y, mo, d, h, mi, s, kind, lsel;
		logic [LEN_W-1:0]  len;
		logic [DATE_W-1:0] date;
		logic [TIME_W-1:0] tm;
		logic [CHAR_W-1:0] sep, zone;
		logic signed [OFFSET_W-1:0] offsets [8];

		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.local_offset_seconds = '0;
		req_ch.valid = 1'b0;
		req_ch.text_length = '0;
		req_ch.date_chars = '0;
		req_ch.separator_char = '0;
		req_ch.time_chars = '0;
		req_ch.zone_char = '0;

		offsets[0] = 17'sd50400;
		offsets[1] = -17'sd50400;
		offsets[2] = 17'sd0;
		offsets[3] = 17'sd3600;
		offsets[4] = OFFSET_W'(int'($urandom_range(100800)) - 50400);
		offsets[5] = -17'sd19800;
		offsets[6] = OFFSET_W'(int'($urandom_range(100800)) - 50400);
		offsets[7] = 17'sd50400;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests at the reset offset
		send_text(5'd0, '1, '1, '1, '1);
		send_text(5'd7, date_text(2024, 1, 1), CHAR_T, clock_text(1, 2, 3), CHAR_Z);
		send_text(LEN_DATE, date_text(1970, 1, 1), 8'h00, '0, 8'h00);
		send_text(LEN_DATE, date_text(2000, 2, 29), CHAR_T, clock_text(12, 0, 0), CHAR_Z);
		send_text(LEN_TIME, date_text(2024, 3, 1), CHAR_T, clock_text(12, 34, 56), CHAR_Z);
		send_text(LEN_ZONE, date_text(2024, 3, 1), CHAR_T, clock_text(12, 34, 56), CHAR_Z);
		send_text(LEN_ZONE, date_text(2024, 3, 1), 8'h58, clock_text(12, 34, 56), CHAR_Z);
		send_text(5'd31, date_text(9999, 12, 31), CHAR_T, clock_text(23, 59, 59), CHAR_Z);
		send_text(LEN_ZONE, date_text(0, 1, 1), CHAR_T, clock_text(0, 0, 0), CHAR_Z);
		send_text(LEN_ZONE, date_text(1900, 3, 1), CHAR_T, clock_text(0, 0, 0), CHAR_Z);
		send_text(LEN_ZONE, date_text(2100, 2, 28), CHAR_T, clock_text(23, 59, 60), CHAR_Z);
		send_text(LEN_ZONE, date_text(1600, 3, 1), CHAR_T, clock_text(6, 0, 0), CHAR_Z);
		send_text(LEN_DATE, date_text(2024, 0, 1), CHAR_T, '0, 8'h00);
		send_text(LEN_ZONE, date_text(2024, 13, 1), CHAR_T, clock_text(1, 1, 1), CHAR_Z);
		send_text(LEN_ZONE, '1, CHAR_T, '1, CHAR_Z);
		// stray bytes far above and below the digits push the sum into saturation
		send_text(LEN_ZONE, {32'hFFFF_FFFF, two_digits(12), 16'hFFFF}, CHAR_T, '1, CHAR_Z);
		send_text(LEN_ZONE, {32'h0, two_digits(1), 16'h0}, CHAR_T, '0, CHAR_Z);
		send_text(LEN_ZONE, {two_digits(19), two_digits(99), 8'h30, 8'h3A, 8'h33, 8'h2F},
			CHAR_T, clock_text(10, 0, 0), CHAR_Z);
		send_text(LEN_DATE, {two_digits(20), two_digits(24), 8'h31, 8'h2F, two_digits(15)},
			8'h00, '0, 8'h00);
		send_text(LEN_ZONE, date_text(2023, 7, 4), CHAR_T, clock_text(8, 30, 0), 8'h7A);
		send_text(5'd17, date_text(2023, 12, 31), CHAR_T, clock_text(24, 0, 0), CHAR_Z);
		send_text(LEN_ZONE, date_text(2001, 1, 1), CHAR_T, '0, CHAR_Z);

		for (int phase = 0; phase < 8; phase++) begin
			write_offset(offsets[phase]);
			send_idle_pct = (phase % 4 == 1) ? 63 : (phase % 4 == 3) ? 24 : 0;
			stall_pct <= (phase % 4 == 2) ? 63 : (phase % 4 == 3) ? 24 : 0;
			for (int n = 0; n < 200; n++) begin
				if (phase == 5 && n == 100)
					wait_all_results();
				kind = $urandom_range(99);
				y = $urandom_range(9999);
				mo = $urandom_range(1, 12);
				d = $urandom_range(1, 31);
				h = $urandom_range(23);
				mi = $urandom_range(59);
				s = $urandom_range(60);
				if (kind >= 70 && kind < 80)
					mo = $urandom_range(1) ? 0 : $urandom_range(13, 99);
				date = date_text(y, mo, d);
				tm = clock_text(h, mi, s);
				lsel = $urandom_range(9);
				len = (lsel < 2) ? LEN_DATE : (lsel == 2) ? LEN_TIME : (lsel < 8) ? LEN_ZONE :
					LEN_W'($urandom_range(17, 31));
				sep = ($urandom_range(9) != 0) ? CHAR_T : CHAR_W'($urandom_range(255));
				zone = ($urandom_range(9) < 6) ? CHAR_Z : CHAR_W'($urandom_range(255));
				if (kind >= 80 && kind < 88) begin
					// junk in year, day and time, month kept legal
					date = {$urandom, $urandom};
					date[31:16] = two_digits(mo);
					tm = TIME_W'({$urandom, $urandom});
				end else if (kind >= 88) begin
					date = {$urandom, $urandom};
					tm = TIME_W'({$urandom, $urandom});
					len = LEN_W'($urandom_range(31));
					sep = $urandom_range(1) ? CHAR_T : CHAR_W'($urandom_range(255));
					zone = CHAR_W'($urandom_range(255));
				end
				send_text(len, date, sep, tm, zone);
			end
		end

		wait_all_results();
		repeat (20) @(posedge clk);
		$display("Covered %0d requests across %0d offset settings and four idle mixes;",
			sent, offset_writes);
		$display("%0d results checked, %0d of them with a bad month.", checked, flagged);
		if (errors == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
